/* hdl/wcdh_pkg.sv */
// ----------------------------------------------------------------------------
// wcdh_pkg
// Shared types and constants for the wide-character decimal/hex to integer
// converter: parse phases, status codes and the code units it looks for.
// ----------------------------------------------------------------------------
package wcdh_pkg;

    localparam int unsigned CU_W   = 16;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned STAT_W = 2;

    // code units of interest
    localparam logic [CU_W-1:0] CU_TERM  = 16'h0000;
    localparam logic [CU_W-1:0] CU_MINUS = 16'h002D;
    localparam logic [CU_W-1:0] CU_PLUS  = 16'h002B;
    localparam logic [CU_W-1:0] CU_ZERO  = 16'h0030;
    localparam logic [CU_W-1:0] CU_NINE  = 16'h0039;
    localparam logic [CU_W-1:0] CU_UP_X  = 16'h0058;
    localparam logic [CU_W-1:0] CU_LO_X  = 16'h0078;
    localparam logic [CU_W-1:0] CU_UP_A  = 16'h0041;
    localparam logic [CU_W-1:0] CU_UP_F  = 16'h0046;
    localparam logic [CU_W-1:0] CU_LO_A  = 16'h0061;
    localparam logic [CU_W-1:0] CU_LO_F  = 16'h0066;

    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    // parse phase
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DEC    = 3'd3,
        PH_HEX    = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    // result status
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // parser state carried between words
    typedef struct packed {
        t_phase            phase;
        logic [VAL_W-1:0]  acc;
        logic              neg;
        t_status           err;
    } t_parse_state;

endpackage

/* hdl/wide_char_decimal_hex_to_int_top.sv */
// ----------------------------------------------------------------------------
// wide_char_decimal_hex_to_int_top
// Streaming string-to-integer converter for 16-bit code units with an
// optional sign and "0x" prefix.
// ----------------------------------------------------------------------------
// one code unit word is taken per cycle while no terminator is held; each
// word passes an input register and then updates the parser state in one
// shift-add step, and a terminator's result is loaded into the output
// register when the parser takes the terminator.
// only a terminator waits on the output register: while a result is stalled
// downstream the next terminator holds in the input register, and the words
// behind it stall with it. no result comes for non-terminator words.
module wide_char_decimal_hex_to_int_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [wcdh_pkg::CU_W-1:0]           i_code_unit,
    output logic                                o_stall,
    output logic                                o_valid,
    output logic signed [wcdh_pkg::VAL_W-1:0]   o_value,
    output logic [wcdh_pkg::STAT_W-1:0]         o_status,
    input  logic                                i_stall
);

    logic                      w_mid_valid;
    logic [wcdh_pkg::CU_W-1:0] w_mid_code;
    logic                      w_take;

    // input register
    wcdh_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .o_stall     (o_stall),
        .o_valid     (w_mid_valid),
        .o_code_unit (w_mid_code),
        .i_take      (w_take)
    );

    // parser and result register
    wcdh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_mid_valid),
        .i_code_unit (w_mid_code),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_status    (o_status),
        .i_stall     (i_stall)
    );

    // a taken terminator always leaves a result behind
    a_term_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_mid_code == wcdh_pkg::CU_TERM) |=> o_valid)
        else $error("terminator taken without a result");

    // error results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != wcdh_pkg::ST_OK) |-> (o_value == '0))
        else $error("error result with non-zero value");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == wcdh_pkg::ST_OK || o_status == wcdh_pkg::ST_INVALID ||
                     o_status == wcdh_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    // the parser never takes a word while the input register is empty
    a_take_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_mid_valid)
        else $error("word taken from empty input register");

    // a new result only follows a taken terminator
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!$past(o_valid) || !$past(i_stall))) |->
            $past(w_take && w_mid_code == wcdh_pkg::CU_TERM))
        else $error("result without a terminator");

endmodule

/* hdl/wcdh_in_reg.sv */
// ----------------------------------------------------------------------------
// wcdh_in_reg
// Input register: holds one code unit word until the parser takes it.
// ----------------------------------------------------------------------------
module wcdh_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [wcdh_pkg::CU_W-1:0]    i_code_unit,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [wcdh_pkg::CU_W-1:0]    o_code_unit,
    input  logic                         i_take
);

    logic                      r_valid;
    logic                      n_valid;
    logic [wcdh_pkg::CU_W-1:0] r_code_unit;
    logic                      w_accept;

    // full and not being drained
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code_unit <= i_code_unit;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_code_unit;

endmodule

/* hdl/wcdh_core.sv */
// ----------------------------------------------------------------------------
// wcdh_core
// Parser state, one-word step logic and the result register.
// ----------------------------------------------------------------------------
module wcdh_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [wcdh_pkg::CU_W-1:0]           i_code_unit,
    output logic                                o_take,
    output logic                                o_valid,
    output logic signed [wcdh_pkg::VAL_W-1:0]   o_value,
    output logic [wcdh_pkg::STAT_W-1:0]         o_status,
    input  logic                                i_stall
);

    wcdh_pkg::t_parse_state r_st;
    wcdh_pkg::t_parse_state n_st;
    wcdh_pkg::t_parse_state w_reset_st;

    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [wcdh_pkg::VAL_W-1:0]    r_value;
    logic [wcdh_pkg::STAT_W-1:0]   r_status;
    logic [wcdh_pkg::VAL_W-1:0]    w_res_value;
    wcdh_pkg::t_status             w_res_status;

    logic                          w_term;
    logic                          w_out_free;
    logic                          w_load_out;

    // digit decode and shift-add
    logic                          w_hex;
    logic                          w_is_dec;
    logic                          w_is_uc;
    logic                          w_is_lc;
    logic                          w_digit_ok;
    logic [3:0]                    w_digit;
    logic [wcdh_pkg::VAL_W+3:0]    w_acc_ext;
    logic [wcdh_pkg::VAL_W+3:0]    w_prod;
    logic [wcdh_pkg::VAL_W+3:0]    w_sum;
    logic                          w_ovf;

    assign w_reset_st = '{phase: wcdh_pkg::PH_START, acc: '0, neg: 1'b0,
                          err: wcdh_pkg::ST_OK};

    assign w_term     = (i_code_unit == wcdh_pkg::CU_TERM);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_take     = i_valid && (!w_term || w_out_free);
    assign w_load_out = o_take && w_term;

    // digit value of the word in the current base
    assign w_hex    = (r_st.phase == wcdh_pkg::PH_HEX);
    assign w_is_dec = (i_code_unit >= wcdh_pkg::CU_ZERO) && (i_code_unit <= wcdh_pkg::CU_NINE);
    assign w_is_uc  = (i_code_unit >= wcdh_pkg::CU_UP_A) && (i_code_unit <= wcdh_pkg::CU_UP_F);
    assign w_is_lc  = (i_code_unit >= wcdh_pkg::CU_LO_A) && (i_code_unit <= wcdh_pkg::CU_LO_F);
    assign w_digit_ok = w_is_dec || (w_hex && (w_is_uc || w_is_lc));

    always_comb begin
        if (w_is_dec) begin
            w_digit = i_code_unit[3:0];
        end else begin
            // 'A'..'F' and 'a'..'f' both have 1..6 in the low nibble
            w_digit = i_code_unit[3:0] + 4'd9;
        end
    end

    // accumulator times radix plus digit, kept 4 bits wider for the overflow test
    assign w_acc_ext = {4'b0000, r_st.acc};
    assign w_prod    = w_hex ? (w_acc_ext << 4) : ((w_acc_ext << 3) + (w_acc_ext << 1));
    assign w_sum     = w_prod + {{wcdh_pkg::VAL_W{1'b0}}, w_digit};
    assign w_ovf     = (w_sum[wcdh_pkg::VAL_W+3:wcdh_pkg::VAL_W] != 4'b0000);

    // next parser state: the reset state on a terminator, else the step for the word
    always_comb begin
        n_st = r_st;
        if (w_term) begin
            n_st = w_reset_st;
        end else begin
            case (r_st.phase)
                wcdh_pkg::PH_START,
                wcdh_pkg::PH_SIGNED,
                wcdh_pkg::PH_ZERO,
                wcdh_pkg::PH_DEC,
                wcdh_pkg::PH_HEX: begin
                    if (r_st.phase == wcdh_pkg::PH_START &&
                        i_code_unit == wcdh_pkg::CU_MINUS) begin
                        n_st.neg   = 1'b1;
                        n_st.phase = wcdh_pkg::PH_SIGNED;
                    end else if (r_st.phase == wcdh_pkg::PH_START &&
                                 i_code_unit == wcdh_pkg::CU_PLUS) begin
                        n_st.phase = wcdh_pkg::PH_SIGNED;
                    end else if ((r_st.phase == wcdh_pkg::PH_START ||
                                  r_st.phase == wcdh_pkg::PH_SIGNED) &&
                                 i_code_unit == wcdh_pkg::CU_ZERO) begin
                        // leading zero, may open a hex prefix
                        n_st.acc   = '0;
                        n_st.phase = wcdh_pkg::PH_ZERO;
                    end else if (r_st.phase == wcdh_pkg::PH_ZERO &&
                                 (i_code_unit == wcdh_pkg::CU_UP_X ||
                                  i_code_unit == wcdh_pkg::CU_LO_X)) begin
                        n_st.acc   = '0;
                        n_st.phase = wcdh_pkg::PH_HEX;
                    end else if (!w_digit_ok) begin
                        n_st.err   = wcdh_pkg::ST_INVALID;
                        n_st.acc   = '0;
                        n_st.phase = wcdh_pkg::PH_ERROR;
                    end else if (w_ovf) begin
                        n_st.err   = wcdh_pkg::ST_OVERFLOW;
                        n_st.acc   = '0;
                        n_st.phase = wcdh_pkg::PH_ERROR;
                    end else begin
                        n_st.acc   = w_sum[wcdh_pkg::VAL_W-1:0];
                        n_st.phase = w_hex ? wcdh_pkg::PH_HEX : wcdh_pkg::PH_DEC;
                    end
                end
                wcdh_pkg::PH_ERROR: begin
                    n_st = r_st;
                end
                default: begin
                    n_st.err   = wcdh_pkg::ST_INVALID;
                    n_st.acc   = '0;
                    n_st.phase = wcdh_pkg::PH_ERROR;
                end
            endcase
        end
    end

    // result for a terminator
    always_comb begin
        w_res_status = (r_st.phase == wcdh_pkg::PH_ERROR) ? r_st.err : wcdh_pkg::ST_OK;
        w_res_value  = '0;
        if (w_res_status == wcdh_pkg::ST_OK) begin
            w_res_value = r_st.neg ? ({wcdh_pkg::VAL_W{1'b0}} - r_st.acc) : r_st.acc;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= w_reset_st;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_st <= n_st;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_value  <= w_res_value;
            r_status <= w_res_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the wide-character decimal/hex to integer converter. A table of
// directed strings covers the field extremes and the special cases, then
// random strings (mostly well formed, some broken, some noise) follow. Each
// result is checked against a cycle-free model of the parser, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcdh_pkg::*;

    localparam int WORD_TARGET   = 950;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RESET_CYCLES  = 7;
    localparam int DIRECTED_ROWS = 27;

    // code units that are not in the package
    localparam logic [CU_W-1:0] CU_ONE      = CU_ZERO + 16'd1;
    localparam logic [CU_W-1:0] CU_SLASH    = CU_ZERO - 16'd1;
    localparam logic [CU_W-1:0] CU_COLON    = CU_NINE + 16'd1;
    localparam logic [CU_W-1:0] CU_AT       = CU_UP_A - 16'd1;
    localparam logic [CU_W-1:0] CU_UP_G     = CU_UP_F + 16'd1;
    localparam logic [CU_W-1:0] CU_BACKTICK = CU_LO_A - 16'd1;
    localparam logic [CU_W-1:0] CU_LO_G     = CU_LO_F + 16'd1;
    localparam logic [CU_W-1:0] CU_TOP      = 16'hFFFF;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
    } t_int_result;

    typedef struct packed {
        logic [CU_W-1:0]  unit;
        logic             typed;
        logic [VAL_W-1:0] value;
        t_status          status;
    } t_stim_row;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic [CU_W-1:0]          i_code_unit = '0;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [VAL_W-1:0]  o_value;
    logic [STAT_W-1:0]        o_status;

    // parser model state
    t_phase            scan_phase = PH_START;
    logic [VAL_W-1:0]  scan_acc   = '0;
    logic              scan_neg   = 1'b0;
    t_status           scan_err   = ST_OK;

    t_int_result       awaited_results[$];
    t_int_result       want;
    logic [CU_W-1:0]   string_words[$];
    int                words_sent   = 0;
    int                strings_sent = 0;
    int                failures     = 0;
    int                idle_cycles  = 0;
    bit                calm_spell   = 1'b0;
    bit                draining     = 1'b0;

    // directed strings; expectations typed only where obvious
    t_stim_row stim_table [DIRECTED_ROWS] = '{
        // empty string straight after reset
        '{CU_TERM,   1'b1, 32'd0, ST_OK},
        // sign only
        '{CU_MINUS,  1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd0, ST_OK},
        // signed bare prefix
        '{CU_PLUS,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_UP_X,   1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd0, ST_OK},
        // lone zero then a decimal digit
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_NINE,   1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd9, ST_OK},
        // sign in the middle
        '{CU_ONE,    1'b0, 32'd0, ST_OK},
        '{CU_PLUS,   1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd0, ST_INVALID},
        // top of the code unit range
        '{CU_TOP,    1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd0, ST_INVALID},
        // hex letters of both cases, nine digits overflow
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_LO_X,   1'b0, 32'd0, ST_OK},
        '{CU_LO_F,   1'b0, 32'd0, ST_OK},
        '{CU_UP_A,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_ZERO,   1'b0, 32'd0, ST_OK},
        '{CU_UP_F,   1'b0, 32'd0, ST_OK},
        '{CU_TERM,   1'b1, 32'd0, ST_OVERFLOW}
    };

    wide_char_decimal_hex_to_int_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_status    (o_status),
        .i_stall     (i_stall)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // digit weight of a code unit, -1 when it is not a digit of the radix
    function automatic int digit_value(input logic [CU_W-1:0] cu, input bit hex_mode);
        if (cu >= CU_ZERO && cu <= CU_NINE) return int'(cu - CU_ZERO);
        if (hex_mode && cu >= CU_UP_A && cu <= CU_UP_F) return int'(cu - CU_UP_A) + 10;
        if (hex_mode && cu >= CU_LO_A && cu <= CU_LO_F) return int'(cu - CU_LO_A) + 10;
        return -1;
    endfunction

    // advance the parser model by one word, giving the integer on a terminator
    task automatic parse_unit(input logic [CU_W-1:0] cu, output bit fired,
                              output t_int_result res);
        int          d;
        bit          hex_mode;
        logic [63:0] wide;
        fired = 1'b0;
        res   = '0;
        if (cu == CU_TERM) begin
            fired      = 1'b1;
            res.status = (scan_phase == PH_ERROR) ? scan_err : ST_OK;
            if (res.status == ST_OK)
                res.value = scan_neg ? (32'd0 - scan_acc) : scan_acc;
            scan_phase = PH_START;
            scan_acc   = '0;
            scan_neg   = 1'b0;
            scan_err   = ST_OK;
        end else if (scan_phase == PH_START && cu == CU_MINUS) begin
            scan_neg   = 1'b1;
            scan_phase = PH_SIGNED;
        end else if (scan_phase == PH_START && cu == CU_PLUS) begin
            scan_phase = PH_SIGNED;
        end else if ((scan_phase == PH_START || scan_phase == PH_SIGNED) && cu == CU_ZERO) begin
            scan_acc   = '0;
            scan_phase = PH_ZERO;
        end else if (scan_phase == PH_ZERO && (cu == CU_UP_X || cu == CU_LO_X)) begin
            scan_acc   = '0;
            scan_phase = PH_HEX;
        end else if (scan_phase != PH_ERROR) begin
            hex_mode = (scan_phase == PH_HEX);
            d        = digit_value(cu, hex_mode);
            if (d < 0) begin
                scan_err   = ST_INVALID;
                scan_acc   = '0;
                scan_phase = PH_ERROR;
            end else begin
                wide = {32'd0, scan_acc} * (hex_mode ? 64'd16 : 64'd10) + 64'(d);
                if (wide[63:32] != 32'd0) begin
                    scan_err   = ST_OVERFLOW;
                    scan_acc   = '0;
                    scan_phase = PH_ERROR;
                end else begin
                    scan_acc   = wide[31:0];
                    scan_phase = hex_mode ? PH_HEX : PH_DEC;
                end
            end
        end
    endtask

    // idle length: mostly none or short, a few long, none in a calm spell
    function automatic int idle_span();
        int r;
        if (calm_spell) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [CU_W-1:0] random_digit(input bit hex_mode);
        int r;
        r = hex_mode ? $urandom_range(0, 21) : $urandom_range(0, 9);
        if (r < 10) return CU_ZERO + 16'(r);
        if (r < 16) return CU_UP_A + 16'(r - 10);
        return CU_LO_A + 16'(r - 16);
    endfunction

    // stray word: near misses of the accepted characters or any non-zero unit
    function automatic logic [CU_W-1:0] noise_unit();
        case ($urandom_range(0, 15))
            0:       return CU_MINUS;
            1:       return CU_PLUS;
            2:       return CU_UP_X;
            3:       return CU_LO_X;
            4:       return CU_SLASH;
            5:       return CU_COLON;
            6:       return CU_AT;
            7:       return CU_UP_G;
            8:       return CU_BACKTICK;
            9:       return CU_LO_G;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // one random string without its terminator
    task automatic compose_string();
        int kind;
        int r;
        int digits;
        bit hex_mode;
        string_words.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(0, 5)) string_words.push_back(noise_unit());
            return;
        end
        r = $urandom_range(0, 3);
        if (r == 0) string_words.push_back(CU_MINUS);
        else if (r == 1) string_words.push_back(CU_PLUS);
        hex_mode = ($urandom_range(0, 2) == 0);
        if (hex_mode) begin
            string_words.push_back(CU_ZERO);
            string_words.push_back($urandom_range(0, 1) ? CU_UP_X : CU_LO_X);
        end
        // lengths around the 32-bit limit give large values and overflows
        r = $urandom_range(0, 19);
        if (r == 0) digits = 0;
        else if (r < 12) digits = $urandom_range(1, 4);
        else if (r < 18) digits = $urandom_range(5, hex_mode ? 8 : 10);
        else digits = $urandom_range(hex_mode ? 9 : 10, hex_mode ? 10 : 12);
        repeat (digits) string_words.push_back(random_digit(hex_mode));
        // broken string: one stray word somewhere
        if (kind < 25)
            string_words.insert($urandom_range(0, string_words.size()), noise_unit());
    endtask

    // present one word, wait for it to be taken, then update the model
    task automatic send_word(input logic [CU_W-1:0] cu, input bit typed,
                             input logic [VAL_W-1:0] val, input t_status st);
        int          gap;
        bit          taken;
        bit          fired;
        t_int_result res;
        gap = idle_span();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        parse_unit(cu, fired, res);
        if (fired) begin
            if (typed) begin
                res.value  = val;
                res.status = st;
            end
            awaited_results.push_back(res);
        end
        words_sent++;
    endtask

    // stimulus
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int row = 0; row < DIRECTED_ROWS; row++)
            send_word(stim_table[row].unit, stim_table[row].typed,
                      stim_table[row].value, stim_table[row].status);
        while (words_sent < WORD_TARGET) begin
            calm_spell = (strings_sent % 40) >= 32;
            compose_string();
            foreach (string_words[k]) send_word(string_words[k], 1'b0, '0, ST_OK);
            send_word(CU_TERM, 1'b0, '0, ST_OK);
            strings_sent++;
        end
        calm_spell = 1'b0;
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("wide_char_decimal_hex_to_int_top test passed");
        else
            $display("wide_char_decimal_hex_to_int_top test failed");
        $finish;
    end

    // output back-pressure
    initial begin
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            n = idle_span();
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // result check, sampled mid-cycle when everything has settled
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: value %h status %0d", o_value, o_status);
                failures++;
            end else begin
                want = awaited_results.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, o_value);
                    failures++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge i_clk) begin
        if (!i_rst_n || draining || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("wide_char_decimal_hex_to_int_top test failed");
                $finish;
            end
        end
    end

endmodule

/* wide_char_decimal_hex_to_int_top.f */
hdl/wcdh_pkg.sv
hdl/wcdh_in_reg.sv
hdl/wcdh_core.sv
hdl/wide_char_decimal_hex_to_int_top.sv
bench/tb.sv
